// ===== sv/pas_pkg.sv =====
// Shared types and constants for the packet arrival scoreboard.
package pas_pkg;

   localparam int MAX_SLOTS_DEF = 4096;

   localparam int CMD_W    = 2;
   localparam int PARCEL_W = 6;
   localparam int PACKET_W = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 13;
   localparam int CFG_W    = 7;
   localparam int SLOT_W   = 13;
   localparam int TOTAL_W  = 2 * CFG_W;
   localparam int CSR_IDX_W = 4;

   localparam logic [CMD_W-1:0] CMD_MARK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNMARK = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MIS = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OOR = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_PACKETS_PER_PARCEL = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PARCEL_COUNT       = 4'd1;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [PARCEL_W-1:0] parcel;
      logic [PACKET_W-1:0] packet;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                mark;
      logic [COUNT_W-1:0]  count;
      logic                complete;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic calc;
      logic update;
      logic clear_step;
      logic load_rsp;
   } pas_ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_is_clear;
      logic clear_last;
      logic rsp_free;
   } pas_sts_type;

endpackage

// ===== sv/pas_ram.sv =====
// Generic simple dual-port RAM with registered read.
module pas_ram
   import pas_pkg::*;
#(
   parameter int Width = 1,
   parameter int Depth = MAX_SLOTS_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/pas_ctrl.sv =====
// Controller state machine of the packet arrival scoreboard.
module pas_ctrl
   import pas_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  pas_sts_type sts,
   output pas_ctl_type ctl
);

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_CALC   = 5'b00100,
      S_UPDATE = 5'b01000,
      S_DONE   = 5'b10000
   } pas_state_type;

   pas_state_type state_ff, state_in;
   logic          pending_ff, pending_in;

   always_comb begin
      state_in       = state_ff;
      pending_in     = pending_ff;
      req_ready      = 1'b0;
      ctl            = '0;
      case (state_ff)
         S_CLEAR: begin
            ctl.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in   = pending_ff ? S_DONE : S_IDLE;
               pending_in = 1'b0;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.accept = 1'b1;
               if (sts.req_is_clear) begin
                  // A clear-all item answers only after the sweep is over.
                  state_in   = S_CLEAR;
                  pending_in = 1'b1;
               end else begin
                  state_in = S_CALC;
               end
            end
         end
         S_CALC: begin
            ctl.calc = 1'b1;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            ctl.update = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ===== sv/pas_dpath.sv =====
// Datapath of the packet arrival scoreboard: config, mark store, count, result.
module pas_dpath
   import pas_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_data,
   output rsp_type              rsp_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  pas_ctl_type          ctl,
   output pas_sts_type          sts
);

   localparam int AddrW = $clog2(MAX_SLOTS);

   logic [CFG_W-1:0]    ppp_ff, parcels_ff;
   logic [CMD_W-1:0]    cmd_ff;
   logic [PARCEL_W-1:0] parcel_ff;
   logic [PACKET_W-1:0] packet_ff;
   logic [AddrW-1:0]    slot_ff;
   logic                range_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                mark_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [AddrW-1:0]    clr_addr_ff;
   rsp_type             rsp_ff;
   logic                rsp_valid_ff;

   logic [SLOT_W-1:0]  slot_calc;
   logic               range_calc;
   logic               prior;
   logic               write_hit;
   logic               ram_we;
   logic [AddrW-1:0]   ram_waddr;
   logic               ram_wdata;
   logic               ram_rdata;
   logic [TOTAL_W-1:0] total;

   // Slot index and range check from the captured request.
   assign slot_calc = SLOT_W'(parcel_ff) * SLOT_W'(ppp_ff) + SLOT_W'(packet_ff);
   assign range_calc = (CFG_W'(packet_ff) < ppp_ff) && (CFG_W'(parcel_ff) < parcels_ff)
                       && (32'(slot_calc) < MAX_SLOTS);

   assign prior = range_ff & ram_rdata;
   assign write_hit = range_ff &&
                      (((cmd_ff == CMD_MARK) && !prior) || ((cmd_ff == CMD_UNMARK) && prior));

   always_comb begin
      status_in = ST_OK;
      if (!range_ff) begin
         status_in = ST_OOR;
      end else if ((cmd_ff == CMD_MARK) && prior) begin
         status_in = ST_DUP;
      end else if ((cmd_ff == CMD_UNMARK) && !prior) begin
         status_in = ST_MIS;
      end
   end

   assign ram_we    = ctl.clear_step || (ctl.update && write_hit);
   assign ram_waddr = ctl.clear_step ? clr_addr_ff : slot_ff;
   assign ram_wdata = !ctl.clear_step && (cmd_ff == CMD_MARK);

   pas_ram #(
      .Width (1),
      .Depth (MAX_SLOTS)
   ) u_marks (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ctl.calc),
      .raddr (AddrW'(slot_calc)),
      .rdata (ram_rdata)
   );

   assign total = TOTAL_W'(ppp_ff) * TOTAL_W'(parcels_ff);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ppp_ff     <= CFG_RESET;
         parcels_ff <= CFG_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_PACKETS_PER_PARCEL) begin
            ppp_ff <= csr_data;
         end else if (csr_index == CSR_PARCEL_COUNT) begin
            parcels_ff <= csr_data;
         end
      end
   end

   // Control state: sweep address, mark count, result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.clear_step) begin
            clr_addr_ff <= sts.clear_last ? '0 : clr_addr_ff + 1'b1;
         end
         if (ctl.accept && sts.req_is_clear) begin
            count_ff <= '0;
         end else if (ctl.update && write_hit) begin
            count_ff <= (cmd_ff == CMD_MARK) ? count_ff + 1'b1 : count_ff - 1'b1;
         end
         if (ctl.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff    <= req_data.command;
         parcel_ff <= req_data.parcel;
         packet_ff <= req_data.packet;
         status_ff <= ST_OK;
         mark_ff   <= 1'b0;
      end
      if (ctl.calc) begin
         slot_ff  <= AddrW'(slot_calc);
         range_ff <= range_calc;
      end
      if (ctl.update) begin
         status_ff <= status_in;
         mark_ff   <= prior;
      end
      if (ctl.load_rsp) begin
         rsp_ff.status   <= status_ff;
         rsp_ff.mark     <= mark_ff;
         rsp_ff.count    <= count_ff;
         rsp_ff.complete <= ({1'b0, count_ff} == total);
      end
   end

   assign sts.req_is_clear = (req_data.command == CMD_CLEAR);
   assign sts.clear_last   = (clr_addr_ff == AddrW'(MAX_SLOTS - 1));
   assign sts.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_SLOTS)
      else $error("mark count exceeds the number of slots");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while a result is still held");

   a_mark_clear_slot: assert property (@(posedge clock) disable iff (reset)
      (ctl.update && ram_we && ram_wdata) |-> !ram_rdata)
      else $error("mark written over a slot that was already set");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      (ctl.accept && sts.req_is_clear) |=> (count_ff == '0))
      else $error("count not zero after a clear-all item");

endmodule

// ===== sv/packet_arrival_scoreboard_core.sv =====
// A mark, unmark or query item steps through CALC, UPDATE and DONE (read-modify-write of
// the mark RAM) and loads its result in DONE once the output register is free; no new item
// is taken before that. A clear-all item sweeps the mark RAM one entry a cycle.
// Reset (synchronous) runs the same sweep over all MAX_SLOTS entries with no request accepted;
// configuration writes are taken at any time, and the registers reset to 64 and 64.
// The output register lets a result wait while the next item is accepted.
module packet_arrival_scoreboard_core
   import pas_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   pas_ctl_type ctl;
   pas_sts_type sts;

   assign csr_ready = 1'b1;

   pas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   pas_dpath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ctl       (ctl),
      .sts       (sts)
   );

endmodule
